FILE: design/b64d_pkg.sv
// Shared types, constants and the character classifier for the base64 decoder.
package b64d_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [6:0] KIND_PAD = 7'd64;
    localparam logic [6:0] KIND_BAD = 7'd65;

    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_PAD   = 8'h3D;

    localparam logic [1:0] BYTE_HIGH = 2'd0;
    localparam logic [1:0] BYTE_MID  = 2'd1;
    localparam logic [1:0] BYTE_LOW  = 2'd2;

    // One queued job: a decoded group or the status item that closes a bad stream.
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  count;
        logic        status;
        logic        last;
    } b64d_job_t;

    // Sextet value 0..63, or KIND_PAD / KIND_BAD.
    function automatic logic [6:0] b64d_classify(input logic [7:0] c);
        logic [6:0] kind;
        kind = KIND_BAD;
        if (c >= 8'h41 && c <= 8'h5A)
            kind = 7'(c - 8'h41);
        else if (c >= 8'h61 && c <= 8'h7A)
            kind = 7'(c - 8'h47);
        else if (c >= 8'h30 && c <= 8'h39)
            kind = 7'(c + 8'd4);
        else if (c == CHAR_PLUS)
            kind = 7'd62;
        else if (c == CHAR_SLASH)
            kind = 7'd63;
        else if (c == CHAR_PAD)
            kind = KIND_PAD;
        return kind;
    endfunction

endpackage

FILE: design/b64d_front.sv
// Front end: classifies each character, tracks the group state and builds jobs.
module b64d_front
    import b64d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] char_code,
    input  logic       last_char,
    output logic       push,
    output b64d_job_t  job
);

    logic [17:0] sextet_reg, sextet_next;
    logic [1:0]  qpos_reg, qpos_next;
    logic [1:0]  pad_reg, pad_next;
    logic        closed_reg, closed_next;
    logic        error_reg, error_next;

    always_comb
    begin
        logic [6:0] kind;
        logic       is_pad;
        logic       err;
        logic [5:0] v;
        logic [1:0] pad_n;
        logic [1:0] n;
        logic [23:0] w;

        kind   = b64d_classify(char_code);
        is_pad = (kind == KIND_PAD);
        err    = 1'b0;
        v      = '0;
        pad_n  = pad_reg;
        n      = '0;
        w      = '0;

        sextet_next = sextet_reg;
        qpos_next   = qpos_reg;
        pad_next    = pad_reg;
        closed_next = closed_reg;
        error_next  = error_reg;

        if (!error_reg)
        begin
            if (closed_reg || kind == KIND_BAD)
                err = 1'b1;
            else if (is_pad)
            begin
                if (qpos_reg < 2'd2)
                    err = 1'b1;
                else
                    pad_n = pad_reg + 2'd1;
            end
            else
            begin
                if (pad_reg != 2'd0)
                    err = 1'b1;
                else
                    v = kind[5:0];
            end

            if (err)
                error_next = 1'b1;
            else if (qpos_reg < 2'd3)
            begin
                sextet_next = {sextet_reg[11:0], v};
                qpos_next   = qpos_reg + 2'd1;
                pad_next    = pad_n;
            end
            else
            begin
                w = {sextet_reg, v};
                n = 2'd3 - pad_n;
                if (pad_n != 2'd0)
                    closed_next = 1'b1;
                sextet_next = '0;
                qpos_next   = '0;
                pad_next    = '0;
            end
        end

        job.word   = w;
        job.count  = n;
        job.status = 1'b0;
        job.last   = last_char;

        if (last_char)
        begin
            if (error_next || qpos_next != 2'd0 || n == 2'd0)
            begin
                job.word   = '0;
                job.count  = 2'd1;
                job.status = 1'b1;
            end
            sextet_next = '0;
            qpos_next   = '0;
            pad_next    = '0;
            closed_next = 1'b0;
            error_next  = 1'b0;
        end

        push = accept && (n != 2'd0 || last_char);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sextet_reg <= '0;
            qpos_reg   <= '0;
            pad_reg    <= '0;
            closed_reg <= 1'b0;
            error_reg  <= 1'b0;
        end
        else if (accept)
        begin
            sextet_reg <= sextet_next;
            qpos_reg   <= qpos_next;
            pad_reg    <= pad_next;
            closed_reg <= closed_next;
            error_reg  <= error_next;
        end
    end

endmodule

FILE: design/b64d_queue.sv
// Short job queue between the front end and the byte emitter.
module b64d_queue
    import b64d_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  b64d_job_t push_job,
    input  logic      pop,
    output logic      full,
    output logic      empty,
    output b64d_job_t head
);

    b64d_job_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

endmodule

FILE: design/b64d_back.sv
// Back end: walks the head job one byte at a time into the output register.
module b64d_back
    import b64d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       empty,
    input  b64d_job_t  head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] data_byte,
    output logic       byte_valid,
    output logic       last_byte,
    output logic       bad_input
);

    logic       valid_reg;
    logic [1:0] idx_reg;
    logic [7:0] data_reg;
    logic       bvalid_reg;
    logic       last_reg;
    logic       bad_reg;
    logic       load;
    logic       final_idx;
    logic [7:0] sel_byte;

    assign load      = (!valid_reg || out_ready) && !empty;
    assign final_idx = (idx_reg == head.count - 2'd1);
    assign pop       = load && final_idx;

    always_comb
    begin
        case (idx_reg)
            BYTE_HIGH: sel_byte = head.word[23:16];
            BYTE_MID:  sel_byte = head.word[15:8];
            BYTE_LOW:  sel_byte = head.word[7:0];
            default:   sel_byte = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= final_idx ? 2'd0 : idx_reg + 2'd1;
            end
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg   <= head.status ? 8'd0 : sel_byte;
            bvalid_reg <= !head.status;
            last_reg   <= head.last && final_idx;
            bad_reg    <= head.status;
        end
    end

    assign out_valid  = valid_reg;
    assign data_byte  = data_reg;
    assign byte_valid = bvalid_reg;
    assign last_byte  = last_reg;
    assign bad_input  = bad_reg;

endmodule

FILE: design/base64_validating_decoder_core.sv
// Top level of the validating base64 stream decoder.
// Usage:
//   Input channel (in_valid/in_ready) takes one character per item in
//   char_code, with last_char set on the final character of a stream.
//   Output channel (out_valid/out_ready) gives one decoded byte per item.
//   A complete group of four characters gives three, two or one bytes;
//   the final byte of a good stream carries last_byte. A bad stream ends
//   in one item with byte_valid low, last_byte and bad_input high, and
//   everything already sent for that stream must be dropped.
// Timing:
//   One character is taken per cycle while the four-entry job queue has
//   room. Each decoded group waits in the job queue, and its bytes
//   leave the output register one per cycle while out_ready is high,
//   so the output register sets the byte rate at one per cycle.
// Reset clears the group state, the queue and the output valid flag.
// When the receiver stalls, the output holds, the queue fills and
// in_ready drops once four jobs are waiting.
module base64_validating_decoder_core
    import b64d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    input  logic       last_char,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] data_byte,
    output logic       byte_valid,
    output logic       last_byte,
    output logic       bad_input
);

    logic      accept;
    logic      push;
    logic      pop;
    logic      full;
    logic      empty;
    b64d_job_t job;
    b64d_job_t head;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;

    b64d_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_code (char_code),
        .last_char (last_char),
        .push      (push),
        .job       (job)
    );

    b64d_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (job),
        .pop      (pop),
        .full     (full),
        .empty    (empty),
        .head     (head)
    );

    b64d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .empty      (empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .data_byte  (data_byte),
        .byte_valid (byte_valid),
        .last_byte  (last_byte),
        .bad_input  (bad_input)
    );

endmodule

FILE: design/b64d_checker.sv
// Port-level checks for the base64 decoder, bound to the top level.
module b64d_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] char_code,
    input logic       last_char,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] data_byte,
    input logic       byte_valid,
    input logic       last_byte,
    input logic       bad_input
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(char_code) && $stable(last_char))
        else $error("input item changed while waiting");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_byte)
            && $stable(byte_valid) && $stable(last_byte) && $stable(bad_input))
        else $error("output item changed while stalled");

    a_bad_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_input |-> last_byte && !byte_valid)
        else $error("bad_input on an item that is not a final status item");

    a_status_is_bad: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> bad_input)
        else $error("status-only item without bad_input");

    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output item present straight after reset");

endmodule

bind base64_validating_decoder_core b64d_checker u_b64d_checker (.*);
